@@ rtl/video_chip_port_interface_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the video chip port interface
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VIDEO_CHIP_PORT_INTERFACE_CORE_ASSERT_SVH
`define VIDEO_CHIP_PORT_INTERFACE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define VCPI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define VCPI_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define VCPI_ASSERT(lbl, prop, msg)
`define VCPI_NEVER(lbl, expr, msg)

`endif

`endif

@@ rtl/vcpi_pkg.sv @@
// ----------------------------------------------------------------------------
// vcpi_pkg
// Shared types and constants of the video chip port interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vcpi_pkg;

  localparam int VRAM_ADDR_BITS_DEF = 14;
  localparam int VRAM_PORT_BITS     = 14;

  // Register whose write also loads the palette pointer.
  localparam logic [5:0] PAL_REG_INDEX = 6'd16;

  typedef enum logic [1:0] {
    CMD_CTRL = 2'd0,
    CMD_DATA = 2'd1,
    CMD_PAL  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic                      vram_we;
    logic [VRAM_PORT_BITS-1:0] vram_addr;
    logic [7:0]                vram_data;
    logic                      reg_we;
    logic [5:0]                reg_index;
    logic [7:0]                reg_value;
    logic                      pal_we;
    logic [3:0]                pal_index;
    logic [2:0]                pal_red;
    logic [2:0]                pal_green;
    logic [2:0]                pal_blue;
  } result_t;

endpackage

@@ rtl/video_chip_port_interface_core.sv @@
// ----------------------------------------------------------------------------
// video_chip_port_interface_core
// Bus side of a video display processor: control latch, video memory
// pointer and palette pair latch, one result per port request.
// Each result is registered in the output register, or in the skid entry while that is held.
// Throughput: one request per cycle while in_stall_o is low; the port state is updated in that cycle.
// A two-entry output stage (result register plus skid) sets the input stall.
// Reset clears all latches, pointers and the output stage at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "video_chip_port_interface_core_assert.svh"

module video_chip_port_interface_core #(
  parameter int VRAM_ADDR_BITS = vcpi_pkg::VRAM_ADDR_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [7:0]                          data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                vram_we_o,
  output logic [vcpi_pkg::VRAM_PORT_BITS-1:0] vram_addr_o,
  output logic [7:0]                          vram_data_o,
  output logic                                reg_we_o,
  output logic [5:0]                          reg_index_o,
  output logic [7:0]                          reg_value_o,
  output logic                                pal_we_o,
  output logic [3:0]                          pal_index_o,
  output logic [2:0]                          pal_red_o,
  output logic [2:0]                          pal_green_o,
  output logic [2:0]                          pal_blue_o
);

  import vcpi_pkg::*;

  logic                      ctrl_phase_q, ctrl_phase_d;
  logic [7:0]                ctrl_latch_q, ctrl_latch_d;
  logic [VRAM_ADDR_BITS-1:0] vram_ptr_q, vram_ptr_d;
  logic                      pal_phase_q, pal_phase_d;
  logic [5:0]                pal_latch_q, pal_latch_d;
  logic [3:0]                pal_ptr_q, pal_ptr_d;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res_new;

  logic in_accept;
  logic out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_comb begin
    res_new      = '0;
    ctrl_phase_d = ctrl_phase_q;
    ctrl_latch_d = ctrl_latch_q;
    vram_ptr_d   = vram_ptr_q;
    pal_phase_d  = pal_phase_q;
    pal_latch_d  = pal_latch_q;
    pal_ptr_d    = pal_ptr_q;
    case (command_i)
      CMD_CTRL: begin
        if (!ctrl_phase_q) begin
          ctrl_latch_d = data_i;
          ctrl_phase_d = 1'b1;
        end else begin
          ctrl_phase_d = 1'b0;
          if (data_i[7]) begin
            res_new.reg_we    = 1'b1;
            res_new.reg_index = data_i[5:0];
            res_new.reg_value = ctrl_latch_q;
            if (data_i[5:0] == PAL_REG_INDEX) begin
              pal_ptr_d   = ctrl_latch_q[3:0];
              pal_phase_d = 1'b0;
            end
          end else begin
            // The pointer load gives fourteen bits, zero-extended or truncated to VRAM_ADDR_BITS.
            vram_ptr_d = VRAM_ADDR_BITS'({data_i[5:0], ctrl_latch_q});
          end
        end
      end
      CMD_DATA: begin
        ctrl_phase_d      = 1'b0;
        res_new.vram_we   = 1'b1;
        res_new.vram_addr = vram_ptr_q[VRAM_PORT_BITS-1:0];
        res_new.vram_data = data_i;
        vram_ptr_d        = vram_ptr_q + VRAM_ADDR_BITS'(1);
      end
      CMD_PAL: begin
        if (!pal_phase_q) begin
          pal_latch_d = {data_i[6:4], data_i[2:0]};
          pal_phase_d = 1'b1;
        end else begin
          pal_phase_d       = 1'b0;
          res_new.pal_we    = 1'b1;
          res_new.pal_index = pal_ptr_q;
          res_new.pal_red   = pal_latch_q[5:3];
          res_new.pal_green = data_i[2:0];
          res_new.pal_blue  = pal_latch_q[2:0];
          pal_ptr_d         = pal_ptr_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_phase_q <= 1'b0;
      ctrl_latch_q <= '0;
      vram_ptr_q   <= '0;
      pal_phase_q  <= 1'b0;
      pal_latch_q  <= '0;
      pal_ptr_q    <= '0;
    end else if (in_accept) begin
      ctrl_phase_q <= ctrl_phase_d;
      ctrl_latch_q <= ctrl_latch_d;
      vram_ptr_q   <= vram_ptr_d;
      pal_phase_q  <= pal_phase_d;
      pal_latch_q  <= pal_latch_d;
      pal_ptr_q    <= pal_ptr_d;
    end
  end

  // A result taken while the output register is held goes to the skid entry,
  // which drains into the output register ahead of any new request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= res_new;
      end
    end else if (in_accept) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign vram_we_o   = out_q.vram_we;
  assign vram_addr_o = out_q.vram_addr;
  assign vram_data_o = out_q.vram_data;
  assign reg_we_o    = out_q.reg_we;
  assign reg_index_o = out_q.reg_index;
  assign reg_value_o = out_q.reg_value;
  assign pal_we_o    = out_q.pal_we;
  assign pal_index_o = out_q.pal_index;
  assign pal_red_o   = out_q.pal_red;
  assign pal_green_o = out_q.pal_green;
  assign pal_blue_o  = out_q.pal_blue;

  `VCPI_ASSERT(a_one_strobe, out_valid_q |-> $onehot0({vram_we_o, reg_we_o, pal_we_o}), "more than one write strobe in a result")
  `VCPI_NEVER(a_skid_alone, skid_valid_q && !out_valid_q, "skid entry full while output register is empty")
  `VCPI_ASSERT(a_data_clears_ctrl, (in_accept && command_i == CMD_DATA) |=> !ctrl_phase_q, "data request left the control latch half full")
  `VCPI_ASSERT(a_ptr_advance, (in_accept && command_i == CMD_DATA) |=> vram_ptr_q == $past(vram_ptr_q) + VRAM_ADDR_BITS'(1), "video memory pointer did not advance after a data request")

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Port interface regression
// Drives control, data and palette port requests into the core with random
// gaps on the request side and random stalls on the result side. A scoreboard
// tracks the control latch, memory pointer and palette pair, and checks every
// result against its own prediction in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import vcpi_pkg::*;

  localparam int TOTAL_REQUESTS = 1150;
  localparam int QUIET_FROM     = 1000;
  localparam int STALL_LIMIT    = 600;
  localparam int DRAIN_CYCLES   = 8;

  class port_access_scoreboard;
    // Port state as the core should hold it.
    bit                      ctrl_second;
    logic [7:0]              ctrl_held;
    logic [VRAM_PORT_BITS-1:0] vram_ptr;
    bit                      write_mode;
    bit                      pal_second;
    logic [5:0]              pal_held;
    logic [3:0]              pal_ptr;

    result_t expected_writes[$];
    int      mismatches;

    function new();
      ctrl_second = 1'b0;
      ctrl_held   = '0;
      vram_ptr    = '0;
      write_mode  = 1'b0;
      pal_second  = 1'b0;
      pal_held    = '0;
      pal_ptr     = '0;
      mismatches  = 0;
    endfunction

    function result_t predict_access(cmd_e cmd, logic [7:0] b);
      result_t r;
      r = '0;
      case (cmd)
        CMD_CTRL: begin
          if (!ctrl_second) begin
            ctrl_held   = b;
            ctrl_second = 1'b1;
          end else begin
            ctrl_second = 1'b0;
            if (b[7]) begin
              r.reg_we    = 1'b1;
              r.reg_index = b[5:0];
              r.reg_value = ctrl_held;
              if (b[5:0] == PAL_REG_INDEX) begin
                pal_ptr    = ctrl_held[3:0];
                pal_second = 1'b0;
              end
            end else begin
              vram_ptr   = {b[5:0], ctrl_held};
              write_mode = b[6];
            end
          end
        end
        CMD_DATA: begin
          // A data request also drops a half-written control pair.
          ctrl_second = 1'b0;
          r.vram_we   = 1'b1;
          r.vram_addr = vram_ptr;
          r.vram_data = b;
          vram_ptr    = vram_ptr + 1'b1;
        end
        CMD_PAL: begin
          if (!pal_second) begin
            pal_held   = {b[6:4], b[2:0]};
            pal_second = 1'b1;
          end else begin
            pal_second  = 1'b0;
            r.pal_we    = 1'b1;
            r.pal_index = pal_ptr;
            r.pal_red   = pal_held[5:3];
            r.pal_green = b[2:0];
            r.pal_blue  = pal_held[2:0];
            pal_ptr     = pal_ptr + 1'b1;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(cmd_e cmd, logic [7:0] b);
      expected_writes.push_back(predict_access(cmd, b));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_writes.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_writes.pop_front();
      compare_field("vram_we",   32'(want.vram_we),   32'(got.vram_we));
      compare_field("vram_addr", 32'(want.vram_addr), 32'(got.vram_addr));
      compare_field("vram_data", 32'(want.vram_data), 32'(got.vram_data));
      compare_field("reg_we",    32'(want.reg_we),    32'(got.reg_we));
      compare_field("reg_index", 32'(want.reg_index), 32'(got.reg_index));
      compare_field("reg_value", 32'(want.reg_value), 32'(got.reg_value));
      compare_field("pal_we",    32'(want.pal_we),    32'(got.pal_we));
      compare_field("pal_index", 32'(want.pal_index), 32'(got.pal_index));
      compare_field("pal_red",   32'(want.pal_red),   32'(got.pal_red));
      compare_field("pal_green", 32'(want.pal_green), 32'(got.pal_green));
      compare_field("pal_blue",  32'(want.pal_blue),  32'(got.pal_blue));
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                command_i   = CMD_NONE;
  logic [7:0]                data_i      = 8'h00;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic                      vram_we_o;
  logic [VRAM_PORT_BITS-1:0] vram_addr_o;
  logic [7:0]                vram_data_o;
  logic                      reg_we_o;
  logic [5:0]                reg_index_o;
  logic [7:0]                reg_value_o;
  logic                      pal_we_o;
  logic [3:0]                pal_index_o;
  logic [2:0]                pal_red_o;
  logic [2:0]                pal_green_o;
  logic [2:0]                pal_blue_o;

  port_access_scoreboard sb = new();
  int requests_sent = 0;
  bit idling_on = 1'b1;
  bit quiet_tail = 1'b0;

  video_chip_port_interface_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vram_we_o   (vram_we_o),
    .vram_addr_o (vram_addr_o),
    .vram_data_o (vram_data_o),
    .reg_we_o    (reg_we_o),
    .reg_index_o (reg_index_o),
    .reg_value_o (reg_value_o),
    .pal_we_o    (pal_we_o),
    .pal_index_o (pal_index_o),
    .pal_red_o   (pal_red_o),
    .pal_green_o (pal_green_o),
    .pal_blue_o  (pal_blue_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are sampled right after the edge, before any update of it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(cmd_e'(command_i), data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result({vram_we_o, vram_addr_o, vram_data_o, reg_we_o, reg_index_o,
                         reg_value_o, pal_we_o, pal_index_o, pal_red_o, pal_green_o,
                         pal_blue_o});
      end
    end
  end

  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("video_chip_port_interface_core regression: fail");
        $finish;
      end
    end
  end

  // Result-side stalls in bursts.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idling_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_request(cmd_e cmd, logic [7:0] b);
    if (idling_on && !quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    data_i     <= b;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
    quiet_tail = (requests_sent >= QUIET_FROM);
    idling_on  = ((requests_sent / 200) % 3) != 2;
  endtask

  initial begin
    int       kind;
    int       burst;
    logic [7:0] b;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unused command gives an all-zero result.
    send_request(CMD_NONE, 8'hFF);
    // Register 16 with an all-ones value sets the palette pointer to entry 15.
    send_request(CMD_CTRL, 8'hFF);
    send_request(CMD_CTRL, 8'h90);
    // Full-scale red and blue with zero green, then the palette pointer wraps to entry 0.
    send_request(CMD_PAL, 8'hFF);
    send_request(CMD_PAL, 8'h00);
    // Only the ignored bits set in the red/blue byte.
    send_request(CMD_PAL, 8'h88);
    send_request(CMD_PAL, 8'hFF);
    // Top address with write mode, then wrap of the memory pointer.
    send_request(CMD_CTRL, 8'hFF);
    send_request(CMD_CTRL, 8'h7F);
    send_request(CMD_DATA, 8'hAA);
    send_request(CMD_DATA, 8'h55);
    send_request(CMD_CTRL, 8'h00);
    send_request(CMD_CTRL, 8'h00);
    send_request(CMD_DATA, 8'h00);
    // A data request in the middle of a control pair restarts the pair.
    send_request(CMD_CTRL, 8'h12);
    send_request(CMD_DATA, 8'h3C);
    send_request(CMD_CTRL, 8'h34);
    send_request(CMD_CTRL, 8'hBF);
    // Register 16 in the middle of a palette pair drops the half pair.
    send_request(CMD_PAL, 8'h70);
    send_request(CMD_CTRL, 8'h05);
    send_request(CMD_CTRL, 8'h90);
    send_request(CMD_PAL, 8'h07);
    send_request(CMD_PAL, 8'h05);
    // Palette requests leave a pending control byte alone.
    send_request(CMD_CTRL, 8'h21);
    send_request(CMD_PAL, 8'h11);
    send_request(CMD_CTRL, 8'h80);

    while (requests_sent < TOTAL_REQUESTS) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: begin
          // Register write; register 16 gets extra weight.
          b = 8'($urandom_range(0, 255));
          send_request(CMD_CTRL, b);
          b = {$urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1, 6'($urandom_range(0, 63))};
          if ($urandom_range(0, 3) == 0) b[5:0] = PAL_REG_INDEX;
          b[7] = 1'b1;
          send_request(CMD_CTRL, b);
        end
        2, 3: begin
          send_request(CMD_CTRL, 8'($urandom_range(0, 255)));
          b = 8'($urandom_range(0, 255));
          b[7] = 1'b0;
          send_request(CMD_CTRL, b);
        end
        4, 5: begin
          burst = $urandom_range(1, 8);
          repeat (burst) send_request(CMD_DATA, 8'($urandom_range(0, 255)));
        end
        6, 7: begin
          send_request(CMD_PAL, 8'($urandom_range(0, 255)));
          send_request(CMD_PAL, 8'($urandom_range(0, 255)));
        end
        default: begin
          send_request(cmd_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      endcase
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("video_chip_port_interface_core regression: pass");
    end else begin
      $display("video_chip_port_interface_core regression: fail");
    end
    $finish;
  end

endmodule
